>>> sv/grid_color_cycle_finder_assert.svh
// Assertion macros for the grid cycle finder
`ifndef GRID_COLOR_CYCLE_FINDER_ASSERT_SVH
`define GRID_COLOR_CYCLE_FINDER_ASSERT_SVH

// a implies b on the next clock edge
`define GCCF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// a implies b on the same clock edge
`define GCCF_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

`endif

>>> sv/gccf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gccf_pkg;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_SLOTS = MAX_ROWS * MAX_COLS;
  localparam int CELL_W     = $clog2(CELL_SLOTS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int DEPTH_W    = CELL_W + 1;
  localparam int COLOUR_W   = 5;
  localparam int DIM_W      = 7;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic [COLOUR_W-1:0] cell_colour;
    logic                last_cell;
  } cell_item_t;

  typedef struct packed {
    logic cycle_found;
  } result_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;
endpackage
`default_nettype wire

>>> sv/gccf_channels.sv
`timescale 1ns / 1ps
`default_nettype none
interface gccf_cell_if;
  import gccf_pkg::*;
  logic       valid;
  logic       ready;
  cell_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gccf_result_if;
  import gccf_pkg::*;
  logic         valid;
  logic         ready;
  result_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gccf_cfg_if;
  import gccf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/grid_color_cycle_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   role    payload
// cells     sink    cell_colour, last_cell
// result    source  cycle_found
// cfg       sink    index (0 rows, 1 columns), data
//
// A cell that is not last is written to the colour store while the grid is not full.
// A last cell starts the search: a clearing pass over the rows*columns visited
// bits, one a cycle, then a probe of each start cell and a depth-first walk that
// tries each direction, reads in-grid neighbors and pops entries it has finished.
// Reset is synchronous and sets both dimensions to 2; memories are not reset.
// cells and cfg are held off during the search; a waiting result holds cells off.
module grid_color_cycle_finder (
  input  wire logic clk,
  input  wire logic rst,
  gccf_cell_if.sink     cells,
  gccf_result_if.source result,
  gccf_cfg_if.sink      cfg
);
  import gccf_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_NEXT  = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_POPA  = 4'd8;
  localparam logic [3:0] S_POPB  = 4'd9;

  localparam int ENTRY_W = ROW_W + COL_W + DIR_W;

  logic [COLOUR_W-1:0] colour_mem [CELL_SLOTS];
  logic                visited_mem [CELL_SLOTS];
  logic [ENTRY_W-1:0]  stack_mem [CELL_SLOTS];

  logic [3:0]          state;
  logic [DIM_W-1:0]    row_count, column_count;
  logic [CELL_W:0]     cells_loaded;
  logic [DEPTH_W-1:0]  stack_depth;
  logic [CELL_W:0]     clr_ptr, start_idx;
  logic [ROW_W-1:0]    start_row, top_row, par_row, nb_row_q;
  logic [COL_W-1:0]    start_col, top_col, par_col, nb_col_q;
  logic [DIR_W-1:0]    top_dir;
  logic [COLOUR_W-1:0] top_colour, col_rd;
  logic                vis_rd;
  logic [ENTRY_W-1:0]  stk_rd;
  logic [CELL_W-1:0]   nb_idx_q;
  logic                has_par;
  logic                found;
  logic                out_valid;

  logic [DIM_W-1:0]    rows_used, cols_used;
  logic [2*DIM_W-1:0]  total_prod;
  logic [CELL_W:0]     total;
  logic                cell_acc, cfg_acc;
  logic [ROW_W-1:0]    nb_row;
  logic [COL_W-1:0]    nb_col;
  logic                nb_ok;
  logic [ROW_W+DIM_W-1:0] nb_prod;
  logic [CELL_W-1:0]   nb_idx;
  logic [CELL_W-1:0]   rd_addr, stk_addr, push_addr;
  logic                same_col, is_parent, push, closes;
  logic [DIM_W-1:0]    start_col_inc;

  assign rows_used = (row_count > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : row_count;
  assign cols_used = (column_count > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : column_count;
  assign total_prod = rows_used * cols_used;
  assign total = total_prod[CELL_W:0];

  assign cells.ready   = (state == S_LOAD) && !out_valid;
  assign cfg.ready     = (state == S_LOAD);
  assign result.valid  = out_valid;
  assign result.payload.cycle_found = found;

  assign cell_acc = cells.valid && cells.ready;
  assign cfg_acc  = cfg.valid && cfg.ready;

  // neighbor of the top entry in its current direction
  always_comb begin
    nb_row = top_row;
    nb_col = top_col;
    nb_ok  = 1'b0;
    unique case (top_dir)
      DIR_EAST: begin
        nb_col = top_col + COL_W'(1);
        nb_ok  = (DIM_W'(top_col) + DIM_W'(1)) < cols_used;
      end
      DIR_SOUTH: begin
        nb_row = top_row + ROW_W'(1);
        nb_ok  = (DIM_W'(top_row) + DIM_W'(1)) < rows_used;
      end
      DIR_WEST: begin
        nb_col = top_col - COL_W'(1);
        nb_ok  = (top_col != '0);
      end
      DIR_NORTH: begin
        nb_row = top_row - ROW_W'(1);
        nb_ok  = (top_row != '0);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_prod = nb_row * cols_used;
  assign nb_idx  = nb_prod[CELL_W-1:0] + CELL_W'(nb_col);

  assign rd_addr   = (state == S_START) ? start_idx[CELL_W-1:0] : nb_idx;
  assign stk_addr  = (state == S_POP) ? CELL_W'(stack_depth - DEPTH_W'(2))
                                      : CELL_W'(stack_depth - DEPTH_W'(3));
  assign push_addr = CELL_W'(stack_depth - DEPTH_W'(1));

  assign same_col  = (col_rd == top_colour);
  assign is_parent = has_par && (par_row == nb_row_q) && (par_col == nb_col_q);
  assign push      = same_col && !is_parent && !vis_rd;
  assign closes    = same_col && !is_parent && vis_rd;

  assign start_col_inc = DIM_W'(start_col) + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (cell_acc && cells_loaded < total)
      colour_mem[cells_loaded[CELL_W-1:0]] <= cells.payload.cell_colour;
    col_rd <= colour_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) visited_mem[clr_ptr[CELL_W-1:0]] <= 1'b0;
    else if (state == S_PROBE && !vis_rd) visited_mem[start_idx[CELL_W-1:0]] <= 1'b1;
    else if (state == S_CHECK && push) visited_mem[nb_idx_q] <= 1'b1;
    vis_rd <= visited_mem[rd_addr];
  end

  // top of stack lives in registers; an entry is written when pushed over
  always_ff @(posedge clk) begin
    if (state == S_CHECK && push)
      stack_mem[push_addr] <= {top_row, top_col, top_dir};
    stk_rd <= stack_mem[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      row_count <= DIM_W'(2);
      column_count <= DIM_W'(2);
      cells_loaded <= '0;
      stack_depth <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      has_par <= 1'b0;
    end else begin
      if (cfg_acc) begin
        if (cfg.payload.index == REG_ROW_COUNT) row_count <= cfg.payload.data;
        else column_count <= cfg.payload.data;
      end
      if (out_valid && result.ready) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (cell_acc) begin
            if (cells.payload.last_cell) begin
              cells_loaded <= '0;
              clr_ptr <= '0;
              if (total == '0) begin
                found <= 1'b0;
                out_valid <= 1'b1;
              end else state <= S_CLEAR;
            end else if (cells_loaded < total) cells_loaded <= cells_loaded + 1'b1;
          end
        end
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == total - 1'b1) begin
            start_idx <= '0;
            start_row <= '0;
            start_col <= '0;
            state <= S_START;
          end
        end
        S_NEXT: begin
          if (start_idx + 1'b1 == total) begin
            found <= 1'b0;
            out_valid <= 1'b1;
            stack_depth <= '0;
            state <= S_LOAD;
          end else begin
            start_idx <= start_idx + 1'b1;
            if (start_col_inc == cols_used) begin
              start_col <= '0;
              start_row <= start_row + 1'b1;
            end else start_col <= start_col + 1'b1;
            state <= S_START;
          end
        end
        S_START: state <= S_PROBE;
        S_PROBE: begin
          if (vis_rd) state <= S_NEXT;
          else begin
            top_row <= start_row;
            top_col <= start_col;
            top_dir <= DIR_EAST;
            top_colour <= col_rd;
            has_par <= 1'b0;
            stack_depth <= DEPTH_W'(1);
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (top_dir >= DIR_DONE) begin
            if (stack_depth == DEPTH_W'(1)) begin
              stack_depth <= '0;
              state <= S_NEXT;
            end else state <= S_POP;
          end else begin
            top_dir <= top_dir + 1'b1;
            nb_row_q <= nb_row;
            nb_col_q <= nb_col;
            nb_idx_q <= nb_idx;
            if (nb_ok) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (closes) begin
            found <= 1'b1;
            out_valid <= 1'b1;
            stack_depth <= '0;
            state <= S_LOAD;
          end else begin
            if (push) begin
              par_row <= top_row;
              par_col <= top_col;
              has_par <= 1'b1;
              top_row <= nb_row_q;
              top_col <= nb_col_q;
              top_dir <= DIR_EAST;
              stack_depth <= stack_depth + 1'b1;
            end
            state <= S_STEP;
          end
        end
        S_POP: state <= S_POPA;
        S_POPA: begin
          {top_row, top_col, top_dir} <= stk_rd;
          stack_depth <= stack_depth - 1'b1;
          has_par <= stack_depth > DEPTH_W'(2);
          state <= S_POPB;
        end
        S_POPB: begin
          par_row <= stk_rd[ENTRY_W-1 -: ROW_W];
          par_col <= stk_rd[DIR_W +: COL_W];
          state <= S_STEP;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `include "grid_color_cycle_finder_assert.svh"
  `GCCF_ASSERT_SAME(a_busy_not_ready, clk, rst, state != S_LOAD, !cells.ready)
  `GCCF_ASSERT_SAME(a_busy_no_cfg, clk, rst, state != S_LOAD, !cfg.ready)
  `GCCF_ASSERT_NEXT(a_last_starts, clk, rst, cell_acc && cells.payload.last_cell, !cells.ready)
  `GCCF_ASSERT_SAME(a_out_idle, clk, rst, out_valid, !cells.ready)
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gccf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  gccf_cell_if   cells ();
  gccf_result_if result ();
  gccf_cfg_if    cfg ();

  grid_color_cycle_finder DUT (
    .clk(clk), .rst(rst), .cells(cells.sink), .result(result.source), .cfg(cfg.sink)
  );

  // predictor state
  int unsigned grid_rows = 2;
  int unsigned grid_cols = 2;
  logic [COLOUR_W-1:0] colour_mem [CELL_SLOTS];
  int unsigned cells_in;
  logic seen [CELL_SLOTS];
  int unsigned walk_stack [CELL_SLOTS];

  logic expected_cycles [$];
  int fail_count = 0;
  int send_count = 0;

  function automatic logic search_for_cycle();
    int unsigned rows, cols, total, depth, top, here, dir, nxt;
    int nr, nc;
    int dr [4] = '{0, 1, 0, -1};
    int dc [4] = '{1, 0, -1, 0};
    rows = (grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows;
    cols = (grid_cols > MAX_COLS) ? MAX_COLS : grid_cols;
    total = rows * cols;
    foreach (seen[i]) seen[i] = 1'b0;
    for (int unsigned s = 0; s < total; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      walk_stack[0] = s << 3;
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        here = walk_stack[top] >> 3;
        dir = walk_stack[top] & 7;
        if (dir >= 4) begin
          depth--;
          continue;
        end
        walk_stack[top] = (here << 3) | (dir + 1);
        nr = int'(here / cols) + dr[dir];
        nc = int'(here % cols) + dc[dir];
        if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
        nxt = nr * cols + nc;
        if (colour_mem[nxt] != colour_mem[here]) continue;
        if (top > 0 && (walk_stack[top-1] >> 3) == nxt) continue;
        if (seen[nxt]) return 1'b1;
        seen[nxt] = 1'b1;
        walk_stack[depth] = nxt << 3;
        depth++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_cell(logic [COLOUR_W-1:0] colour, logic last);
    int unsigned total;
    total = ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows)
          * ((grid_cols > MAX_COLS) ? MAX_COLS : grid_cols);
    if (cells_in < total) begin
      colour_mem[cells_in] = colour;
      cells_in++;
    end
    if (last) begin
      expected_cycles.push_back(search_for_cycle());
      cells_in = 0;
    end
  endfunction

  // valid stays high after a transaction until the next gap or drain
  task automatic send_cell(logic [COLOUR_W-1:0] colour, logic last);
    int unsigned gap;
    gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells.valid <= 1'b1;
    cells.payload <= '{cell_colour: colour, last_cell: last};
    do @(posedge clk); while (!cells.ready);
    predict_cell(colour, last);
    send_count++;
  endtask

  task automatic drain();
    cells.valid <= 1'b0;
    while (expected_cycles.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.payload <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_ROW_COUNT) grid_rows = val;
    else grid_cols = val;
  endtask

  task automatic set_grid(int unsigned r, int unsigned c);
    drain();
    write_reg(REG_ROW_COUNT, r[DIM_W-1:0]);
    write_reg(REG_COLUMN_COUNT, c[DIM_W-1:0]);
    cfg.valid <= 1'b0;
  endtask

  // full grid plus extra cells; fill 0 random, 1 single colour, 2 two colours, 3 colour from the cell index
  task automatic send_grid(int fill, int extra);
    int unsigned n;
    n = ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows)
      * ((grid_cols > MAX_COLS) ? MAX_COLS : grid_cols);
    for (int unsigned i = 0; i < n + extra; i++) begin
      logic [COLOUR_W-1:0] c;
      case (fill)
        0: c = COLOUR_W'($urandom_range(0, 31));
        1: c = 5'd25;
        2: c = $urandom_range(0, 1) ? 5'd31 : 5'd0;
        default: c = i[COLOUR_W-1:0] ^ (i[9:5]);
      endcase
      send_cell(c, i == n + extra - 1);
    end
  endtask

  task automatic test_directed();
    send_grid(1, 0);      // 2x2 one colour: cycle
    send_grid(3, 0);      // no cycle
    send_grid(2, 2);      // surplus cells
    set_grid(3, 3);
    send_grid(2, 0);
    set_grid(2, 1);       // too narrow to hold a cycle
    send_grid(1, 0);
    set_grid(127, 2);     // saturates to MAX_ROWS
    send_grid(1, 0);
  endtask

  task automatic test_short_grid();
    set_grid(3, 4);
    send_grid(0, 0);
    for (int i = 0; i < 5; i++) send_cell(COLOUR_W'($urandom_range(0, 31)), i == 4);
  endtask

  task automatic test_random();
    while (send_count < 540) begin
      set_grid($urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(2, 6),
               $urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(2, 6));
      // big grids are covered by the directed tests
      if (grid_rows * grid_cols > 64) set_grid($urandom_range(2, 6), $urandom_range(2, 6));
      repeat ($urandom_range(1, 3)) send_grid($urandom_range(0, 2), $urandom_range(0, 1));
    end
  endtask

  task automatic test_wide_grid();
    set_grid(2, 64);
    send_grid(2, 0);
    set_grid(2, 2);
  endtask

  initial begin
    cells.valid = 1'b0;
    cells.payload = '0;
    cfg.valid = 1'b0;
    cfg.payload = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_short_grid();
    test_wide_grid();
    test_random();
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // result sink: raises ready for each result after a randomly drawn hold
  initial begin
    int unsigned hold;
    result.ready = 1'b0;
    forever begin
      do @(posedge clk); while (result.valid !== 1'b1);
      hold = $urandom_range(0, 19);
      repeat (hold) @(posedge clk);
      result.ready <= 1'b1;
      @(posedge clk);
      result.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_cycles.size() == 0) begin
        $error("unexpected result transaction: cycle_found actual %0b",
               result.payload.cycle_found);
        fail_count++;
      end else begin
        logic want;
        want = expected_cycles.pop_front();
        if (result.payload.cycle_found !== want) begin
          $error("cycle_found mismatch: expected %0b actual %0b",
                 want, result.payload.cycle_found);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
